FILE: hdl/hsip_pkg.sv
package hsip_pkg;

  localparam int MAX_LEN_DEFAULT = 4096;
  localparam int RUN_W = 13;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_FF = 8'h0C;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // floor(2^63-1 / 10); largest magnitude that may still take another digit
  localparam logic [63:0] STEP_BASE = 64'd922337203685477580;
  localparam logic [3:0] POS_CUT = 4'd7;
  localparam logic [3:0] NEG_CUT = 4'd8;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic                 ok;
    logic                 is_negative;
    logic                 overflowed;
    logic signed [63:0]   number;
    logic [RUN_W-1:0]     run_offset;
    logic [RUN_W-1:0]     run_length;
  } result_item_t;

  // (limit - d) / 10 for limit 2^63-1 or 2^63, worked out from the remainders 7 and 8
  function automatic logic [63:0] step_limit(input logic [3:0] d, input logic minus);
    logic [3:0] cut;
    cut = minus ? NEG_CUT : POS_CUT;
    return (d > cut) ? (STEP_BASE - 64'd1) : STEP_BASE;
  endfunction

endpackage

FILE: hdl/html_signed_integer_parser_core.sv
// channel   direction  handshake            payload
// text      in         text_valid/stall     hsip_pkg::text_item_t
// result    out        result_valid/stall   hsip_pkg::result_item_t
// cfg       in         cfg_valid/ready      cfg_data (non_negative_mode)
//
// one text item per cycle while text_stall is low; the digit step (limit compare
// and times-ten add on the magnitude register) finishes in the cycle the byte is taken
// a last item's result is registered in the output slot, or in the skid slot if held
// rst is synchronous and clears the parse state, the mode and both result slots
// results sit in an output register backed by a skid register; text_stall is
// high only while the skid register holds a result
module html_signed_integer_parser_core #(
  parameter int MAX_LEN = hsip_pkg::MAX_LEN_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_valid,
  output logic                   text_stall,
  input  hsip_pkg::text_item_t   text_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output hsip_pkg::result_item_t result_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_data
);

  logic                   non_negative_mode;
  logic                   take, push, pop;
  hsip_pkg::result_item_t result_new;
  hsip_pkg::result_item_t skid_data;
  logic                   skid_valid;

  assign cfg_ready = 1'b1;
  assign text_stall = skid_valid;
  assign take = text_valid && !text_stall;
  assign pop = result_valid && !result_stall;

  hsip_parse #(
    .MAX_LEN(MAX_LEN)
  ) u_parse (
    .clk               (clk),
    .rst               (rst),
    .take              (take),
    .item              (text_data),
    .non_negative_mode (non_negative_mode),
    .push              (push),
    .result            (result_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      non_negative_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      non_negative_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (result_valid && !pop) begin
      // output held; park a new result in the skid slot
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result_valid <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      result_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !pop) begin
      if (push) begin
        skid_data <= result_new;
      end
    end else if (skid_valid) begin
      result_data <= skid_data;
    end else if (push) begin
      result_data <= result_new;
    end
  end

endmodule

FILE: hdl/hsip_parse.sv
module hsip_parse #(
  parameter int MAX_LEN = hsip_pkg::MAX_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  hsip_pkg::text_item_t  item,
  input  logic                  non_negative_mode,
  output logic                  push,
  output hsip_pkg::result_item_t result
);

  localparam int POS_W = $clog2(MAX_LEN + 1);
  localparam int RUN_W = hsip_pkg::RUN_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LEN);

  typedef enum logic [3:0] {
    PH_WS     = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  phase_t             phase, phase_next, phase_adv;
  logic [POS_W-1:0]   byte_position, byte_position_next, pos_adv;
  logic [63:0]        magnitude, magnitude_next, mag_adv;
  logic               sign_minus, sign_minus_next, sign_adv;
  logic               overflow_flag, overflow_flag_next, ovf_adv;
  logic [POS_W-1:0]   first_digit_offset, first_digit_offset_next, fdo_adv;
  logic [POS_W-1:0]   digit_count, digit_count_next, dc_adv;
  logic               failed_flag, failed_flag_next, failed_adv;

  logic [7:0]         b;
  logic [3:0]         d;
  logic               is_digit, is_space, take_dig, all_zero;
  logic               parsed, zero_adv, ok;
  logic [63:0]        signed_val;
  logic [POS_W+RUN_W-1:0] ofs_ext, len_ext;

  assign b = item.text_byte;
  assign d = b[3:0];
  assign is_digit = (b >= hsip_pkg::CHAR_ZERO) && (b <= hsip_pkg::CHAR_NINE);
  assign is_space = (b == hsip_pkg::CHAR_SPACE) || (b == hsip_pkg::CHAR_TAB) ||
                    (b == hsip_pkg::CHAR_LF) || (b == hsip_pkg::CHAR_FF) ||
                    (b == hsip_pkg::CHAR_CR);
  assign all_zero = (magnitude == 64'd0) && !overflow_flag;

  // state after the byte of this item
  always_comb begin
    phase_adv = phase;
    pos_adv = byte_position;
    mag_adv = magnitude;
    sign_adv = sign_minus;
    ovf_adv = overflow_flag;
    fdo_adv = first_digit_offset;
    dc_adv = digit_count;
    failed_adv = failed_flag;
    take_dig = 1'b0;
    if (item.has_byte) begin
      unique case (phase)
        PH_WS: begin
          priority if (is_space) begin
          end else if (b == hsip_pkg::CHAR_MINUS) begin
            sign_adv = 1'b1;
            phase_adv = PH_SIGN;
          end else if (b == hsip_pkg::CHAR_PLUS) begin
            phase_adv = PH_SIGN;
          end else if (is_digit) begin
            take_dig = 1'b1;
            phase_adv = PH_DIGITS;
          end else begin
            failed_adv = 1'b1;
            phase_adv = PH_DONE;
          end
        end
        PH_SIGN: begin
          if (is_digit) begin
            take_dig = 1'b1;
            phase_adv = PH_DIGITS;
          end else begin
            failed_adv = 1'b1;
            phase_adv = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            take_dig = 1'b1;
          end else begin
            phase_adv = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
      if (byte_position < POS_MAX) begin
        pos_adv = byte_position + POS_W'(1);
      end
    end
    if (take_dig) begin
      // a leading zero is replaced by the digit after it
      if (digit_count == '0 || (all_zero && digit_count == POS_W'(1))) begin
        fdo_adv = byte_position;
        dc_adv = POS_W'(1);
      end else if (digit_count < POS_MAX) begin
        dc_adv = digit_count + POS_W'(1);
      end
      if (!overflow_flag) begin
        if (magnitude > hsip_pkg::step_limit(d, sign_minus)) begin
          ovf_adv = 1'b1;
        end else begin
          mag_adv = (magnitude << 3) + (magnitude << 1) + {60'd0, d};
        end
      end
    end
  end

  always_comb begin
    parsed = (phase_adv == PH_DIGITS) || (phase_adv == PH_DONE && !failed_adv);
    zero_adv = (mag_adv == 64'd0) && !ovf_adv;
    ok = parsed && !(non_negative_mode && sign_adv && !zero_adv);
    signed_val = sign_adv ? (64'd0 - mag_adv) : mag_adv;
    ofs_ext = {{RUN_W{1'b0}}, fdo_adv};
    len_ext = {{RUN_W{1'b0}}, dc_adv};
    result.ok = ok;
    result.is_negative = sign_adv;
    result.overflowed = parsed && ovf_adv;
    result.number = (ok && !ovf_adv) ? $signed(signed_val) : 64'sd0;
    result.run_offset = parsed ? ofs_ext[RUN_W-1:0] : '0;
    result.run_length = parsed ? len_ext[RUN_W-1:0] : '0;
  end

  assign push = take && item.last;

  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    magnitude_next = magnitude;
    sign_minus_next = sign_minus;
    overflow_flag_next = overflow_flag;
    first_digit_offset_next = first_digit_offset;
    digit_count_next = digit_count;
    failed_flag_next = failed_flag;
    if (take) begin
      if (item.last) begin
        phase_next = PH_WS;
        byte_position_next = '0;
        magnitude_next = 64'd0;
        sign_minus_next = 1'b0;
        overflow_flag_next = 1'b0;
        first_digit_offset_next = '0;
        digit_count_next = '0;
        failed_flag_next = 1'b0;
      end else begin
        phase_next = phase_adv;
        byte_position_next = pos_adv;
        magnitude_next = mag_adv;
        sign_minus_next = sign_adv;
        overflow_flag_next = ovf_adv;
        first_digit_offset_next = fdo_adv;
        digit_count_next = dc_adv;
        failed_flag_next = failed_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WS;
      byte_position <= '0;
      magnitude <= 64'd0;
      sign_minus <= 1'b0;
      overflow_flag <= 1'b0;
      first_digit_offset <= '0;
      digit_count <= '0;
      failed_flag <= 1'b0;
    end else begin
      phase <= phase_next;
      byte_position <= byte_position_next;
      magnitude <= magnitude_next;
      sign_minus <= sign_minus_next;
      overflow_flag <= overflow_flag_next;
      first_digit_offset <= first_digit_offset_next;
      digit_count <= digit_count_next;
      failed_flag <= failed_flag_next;
    end
  end

endmodule
